FILE: rtl/lap3_pkg.sv
// Package for the 3x3 four-neighbour Laplacian filter.
// Holds sizes, register indexes, gain constants and the queue item type.
// No dependencies.
`timescale 1ns / 1ps

package lap3_pkg;

    // Sizing
    localparam int MAX_WIDTH   = 1024;
    localparam int PIXEL_BITS  = 8;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = 12;
    localparam int WIDTH_BITS  = 11;
    localparam int HEIGHT_BITS = 12;
    localparam int CFG_BITS    = (WIDTH_BITS > HEIGHT_BITS) ? WIDTH_BITS : HEIGHT_BITS;

    // Register indexes on the write port
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);

    // Arithmetic: offset, Q0.16 gain of 0.44, saturation bound
    localparam int LAP_OFFSET = 288;
    localparam int GAIN_Q16   = 28836;
    localparam int GAIN_BITS  = 15;
    localparam int FRAC_BITS  = 16;
    localparam int PIXEL_MAX  = (1 << PIXEL_BITS) - 1;
    localparam int SUM_BITS   = (PIXEL_BITS + 4 > 11) ? PIXEL_BITS + 4 : 11;
    localparam int PROD_BITS  = SUM_BITS - 1 + GAIN_BITS;

    // Queue between front and back
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

    // One classified pixel with its neighbours from the row stores
    typedef struct packed {
        logic [PIXEL_BITS-1:0] upper;     // row r-2, column c
        logic [PIXEL_BITS-1:0] middle;    // row r-1, column c
        logic [PIXEL_BITS-1:0] pixel;     // row r, column c
        logic                  emit;      // window centre is interior
        logic                  frame_end; // last interior pixel
    } lap3_item_t;

endpackage

FILE: rtl/lap3_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module lap3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/lap3_front.sv
// Front end: configuration registers, raster counters, classification and
// row store access. Depends on lap3_pkg and lap3_ram.
`timescale 1ns / 1ps

module lap3_front import lap3_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wen,
    input  logic                  cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIXEL_BITS-1:0] s_pixel,
    output logic                  q_valid,
    input  logic                  q_ready,
    output lap3_item_t            q_item
);

    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [COL_BITS-1:0]    col_reg, col_next;
    logic [ROW_BITS-1:0]    row_reg, row_next;

    // Stage 1: item whose row store read is in flight
    logic                  v1_reg, v1_next;
    logic [COL_BITS-1:0]   addr1_reg;
    logic [PIXEL_BITS-1:0] pix1_reg;
    logic                  emit1_reg;
    logic                  fe1_reg;

    logic [WIDTH_BITS-1:0]    w_eff;
    logic [HEIGHT_BITS-1:0]   h_eff;
    logic [COL_BITS-1:0]      col_last;
    logic [ROW_BITS-1:0]      row_last;
    logic                     last_col, last_row, emit, accept;
    logic                     ram_we;
    logic [2*PIXEL_BITS-1:0]  ram_rdata;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata[HEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size and position flags
    always_comb begin
        if (width_reg < WIDTH_BITS'(3)) begin
            w_eff = WIDTH_BITS'(3);
        end else if (width_reg > WIDTH_BITS'(MAX_WIDTH)) begin
            w_eff = WIDTH_BITS'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        h_eff    = (height_reg < HEIGHT_BITS'(3)) ? HEIGHT_BITS'(3) : height_reg;
        col_last = COL_BITS'(w_eff - WIDTH_BITS'(1));
        row_last = ROW_BITS'(h_eff - HEIGHT_BITS'(1));
        last_col = col_reg >= col_last;
        last_row = row_reg >= row_last;
        emit     = (row_reg >= ROW_BITS'(2)) && (col_reg >= COL_BITS'(2));
    end

    assign s_tready = !v1_reg || q_ready;
    assign accept   = s_tvalid && s_tready;

    // Raster counters
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_BITS'(1);
            end else begin
                col_next = col_reg + COL_BITS'(1);
            end
        end
    end

    always_comb begin
        if (accept) begin
            v1_next = 1'b1;
        end else if (q_ready) begin
            v1_next = 1'b0;
        end else begin
            v1_next = v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            v1_reg  <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            v1_reg  <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            addr1_reg <= col_reg;
            pix1_reg  <= s_pixel;
            emit1_reg <= emit;
            fe1_reg   <= emit && last_col && last_row;
        end
    end

    // Both row stores in one word: upper half is row r-2, lower half row r-1.
    // Read at accept, write back shifted rows when the item leaves stage 1.
    assign ram_we = v1_reg && q_ready;

    lap3_ram #(
        .WIDTH (2 * PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_rows (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr1_reg),
        .wdata ({ram_rdata[PIXEL_BITS-1:0], pix1_reg}),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    assign q_valid          = v1_reg;
    assign q_item.upper     = ram_rdata[2*PIXEL_BITS-1:PIXEL_BITS];
    assign q_item.middle    = ram_rdata[PIXEL_BITS-1:0];
    assign q_item.pixel     = pix1_reg;
    assign q_item.emit      = emit1_reg;
    assign q_item.frame_end = fe1_reg;

    // Write-back never collides with the read of the next column
    a_no_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we && accept |-> addr1_reg != col_reg)
        else $error("row store write and read hit the same column");

endmodule

FILE: rtl/lap3_queue.sv
// Short FIFO of classified items between the front and back ends.
// Depends on lap3_pkg.
`timescale 1ns / 1ps

module lap3_queue import lap3_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    output logic       push_ready,
    input  lap3_item_t push_item,
    output logic       pop_valid,
    input  logic       pop_ready,
    output lap3_item_t pop_item
);

    lap3_item_t              slots_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]   wptr_reg, rptr_reg;
    logic [Q_PTR_BITS:0]     count_reg, count_next;
    logic                    push, pop;

    assign push_ready = count_reg != (Q_PTR_BITS+1)'(Q_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = slots_reg[rptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (Q_PTR_BITS+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (Q_PTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + Q_PTR_BITS'(1);
            end
            if (pop) begin
                rptr_reg <= rptr_reg + Q_PTR_BITS'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wptr_reg] <= push_item;
        end
    end

    // Fill level tracks the pointers
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (Q_PTR_BITS+1)'(Q_DEPTH)
        && (count_reg == '0 || count_reg == (Q_PTR_BITS+1)'(Q_DEPTH)
            || Q_PTR_BITS'(wptr_reg - rptr_reg) == count_reg[Q_PTR_BITS-1:0]))
        else $error("queue fill count out of step with pointers");

endmodule

FILE: rtl/lap3_back.sv
// Back end: 3x3 window taps, Laplacian sum, Q0.16 gain, saturation and the
// output register. Depends on lap3_pkg.
`timescale 1ns / 1ps

module lap3_back import lap3_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  lap3_item_t            q_item,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIXEL_BITS-1:0] m_pixel,
    output logic                  m_frame_end
);

    // Window taps: up (r-2,c-1), left (r-1,c-2), centre (r-1,c-1), down (r,c-1)
    logic [PIXEL_BITS-1:0] up_reg, left_reg, centre_reg, down_reg;

    logic                       a_v_reg;
    logic signed [SUM_BITS-1:0] a_sum_reg;
    logic                       a_fe_reg;
    logic                       b_v_reg;
    logic [PROD_BITS-1:0]       b_prod_reg;
    logic                       b_fe_reg;
    logic                       o_v_reg;
    logic [PIXEL_BITS-1:0]      o_pix_reg;
    logic                       o_fe_reg;

    logic                       o_ready, b_ready, a_ready, pop;
    logic signed [SUM_BITS-1:0] sum;
    logic [PROD_BITS-1:0]       prod;
    logic [PROD_BITS-FRAC_BITS-1:0] scaled;
    logic [PIXEL_BITS-1:0]      sat;

    assign o_ready = !o_v_reg || m_tready;
    assign b_ready = !b_v_reg || o_ready;
    assign a_ready = !a_v_reg || b_ready;
    assign pop     = q_valid && a_ready;
    assign q_ready = a_ready;

    // up + down + left + right - 4*centre + offset
    always_comb begin
        sum = SUM_BITS'(up_reg) + SUM_BITS'(down_reg) + SUM_BITS'(left_reg)
            + SUM_BITS'(q_item.middle) - (SUM_BITS'(centre_reg) <<< 2)
            + SUM_BITS'(LAP_OFFSET);
    end

    // Gain applies only to a positive sum; otherwise the result is zero
    always_comb begin
        if (a_sum_reg > 0) begin
            prod = PROD_BITS'(a_sum_reg[SUM_BITS-2:0]) * PROD_BITS'(GAIN_Q16);
        end else begin
            prod = '0;
        end
    end

    always_comb begin
        scaled = b_prod_reg[PROD_BITS-1:FRAC_BITS];
        if (scaled > (PROD_BITS-FRAC_BITS)'(PIXEL_MAX)) begin
            sat = PIXEL_BITS'(PIXEL_MAX);
        end else begin
            sat = scaled[PIXEL_BITS-1:0];
        end
    end

    // Tap shift on every item, interior or not
    always_ff @(posedge aclk) begin
        if (pop) begin
            left_reg   <= centre_reg;
            centre_reg <= q_item.middle;
            up_reg     <= q_item.upper;
            down_reg   <= q_item.pixel;
        end
    end

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_v_reg <= pop && q_item.emit;
            end
            if (b_ready) begin
                b_v_reg <= a_v_reg;
            end
            if (o_ready) begin
                o_v_reg <= b_v_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (a_ready) begin
            a_sum_reg <= sum;
            a_fe_reg  <= q_item.frame_end;
        end
        if (b_ready) begin
            b_prod_reg <= prod;
            b_fe_reg   <= a_fe_reg;
        end
        if (o_ready) begin
            o_pix_reg <= sat;
            o_fe_reg  <= b_fe_reg;
        end
    end

    assign m_tvalid    = o_v_reg;
    assign m_pixel     = o_pix_reg;
    assign m_frame_end = o_fe_reg;

    // A held sum stage keeps its value until the product stage takes it
    a_hold_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        a_v_reg && !b_ready |=> a_v_reg && $stable(a_sum_reg) && $stable(a_fe_reg))
        else $error("sum stage lost a stalled transaction");

    // No transaction is popped while the sum stage is blocked
    a_pop_block: assert property (@(posedge aclk) disable iff (!aresetn)
        a_v_reg && !b_ready |-> !pop)
        else $error("queue popped into a blocked sum stage");

endmodule

FILE: rtl/laplacian_3x3_filter_core.sv
// Top level of the 3x3 four-neighbour Laplacian filter core.
// Depends on lap3_pkg, lap3_front, lap3_queue and lap3_back.
//
//   channel   dir   handshake            payload
//   s_        in    s_tvalid/s_tready    s_tdata[7:0] = pixel_in
//   m_        out   m_tvalid/m_tready    m_tdata[7:0] = pixel_out, m_tlast = frame_end
//   cfg_      in    cfg_wen              cfg_index (0 width, 1 height), cfg_wdata[11:0]
//
// One pixel per clock sustained while the output is not stalled; the row store RAM
// (one read and one write port) is accessed once per pixel. A pixel passes stage 1,
// the queue and the sum, product and output registers. Synchronous active-low reset
// clears counters, valids and the queue; row stores need no clearing. A stalled
// output fills the back pipeline, then the four-entry queue, before s_tready drops.
`timescale 1ns / 1ps

module laplacian_3x3_filter_core import lap3_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wen,
    input  logic                cfg_index,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] pixel_in
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // [7:0] pixel_out
    output logic                m_tlast    // frame_end
);

    logic       fq_valid, fq_ready, qb_valid, qb_ready;
    lap3_item_t fq_item, qb_item;

    lap3_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_pixel   (s_tdata[PIXEL_BITS-1:0]),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_item    (fq_item)
    );

    lap3_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    lap3_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (qb_valid),
        .q_ready     (qb_ready),
        .q_item      (qb_item),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_pixel     (m_tdata[PIXEL_BITS-1:0]),
        .m_frame_end (m_tlast)
    );

endmodule
